### rtl/wbc_pkg.sv
package wbc_pkg;
    localparam int NumWords  = 64;
    localparam int MaxWord   = 32;
    localparam int WordIdxW  = $clog2(NumWords);
    localparam int CountW    = $clog2(NumWords + 1);
    localparam int PosW      = $clog2(MaxWord);
    localparam int LenW      = $clog2(MaxWord + 1);
    localparam int DictAddrW = WordIdxW + PosW;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DICT  = 2'd1,
        OP_START = 2'd2,
        OP_TEXT  = 2'd3
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic                clear_dict;
        logic                dict_char;
        logic                start_text;
        logic                text_shift;
        logic                scan_start;
        logic [WordIdxW-1:0] scan_word;
        logic [PosW-1:0]     scan_pos;
        logic                cmp_step;
        logic                set_hit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [CountW-1:0] word_count;
        logic [LenW-1:0]   cur_len;
        logic              len_ok;
        logic              mismatch;
    } dp_stat_t;
endpackage

### rtl/wbc_datapath.sv
module wbc_datapath
    import wbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  logic [7:0] ch,
    input  logic       word_end,
    output dp_stat_t   stat,
    output logic       dropped
);
    logic [7:0]          dict_mem [NumWords*MaxWord];
    logic [LenW-1:0]     len_mem  [NumWords];
    logic [7:0]          rd_char_reg;
    logic [LenW-1:0]     rd_len_reg;
    logic [CountW-1:0]   count_reg, count_next;
    logic [LenW-1:0]     fill_reg, fill_next;
    logic                bad_reg, bad_next;
    logic                drop_reg, drop_next;
    logic [7:0]          win_reg [MaxWord];
    logic [MaxWord:0]    hist_reg;
    logic                mis_reg;
    logic [PosW-1:0]     pos_d_reg;
    logic                full, too_long, dbad;
    logic [LenW-1:0]     widx;

    assign full     = count_reg >= CountW'(NumWords);
    assign too_long = fill_reg >= LenW'(MaxWord);
    assign dbad     = bad_reg | full | too_long;

    // dictionary load bookkeeping
    always_comb
    begin
        count_next = count_reg;
        fill_next  = fill_reg;
        bad_next   = bad_reg;
        drop_next  = drop_reg;
        if (cmd.clear_dict)
        begin
            count_next = '0;
            fill_next  = '0;
            bad_next   = 1'b0;
            drop_next  = 1'b0;
        end
        else if (cmd.dict_char)
        begin
            if (full || too_long)
                bad_next = 1'b1;
            else if (!bad_reg)
                fill_next = fill_reg + 1'b1;
            if (word_end)
            begin
                if (dbad)
                    drop_next = 1'b1;
                else
                    count_next = count_reg + 1'b1;
                fill_next = '0;
                bad_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fill_reg  <= '0;
            bad_reg   <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            fill_reg  <= fill_next;
            bad_reg   <= bad_next;
            drop_reg  <= drop_next;
        end
    end

    // dictionary memories
    always_ff @(posedge clk)
    begin
        if (cmd.dict_char && !dbad)
        begin
            dict_mem[{count_reg[WordIdxW-1:0], fill_reg[PosW-1:0]}] <= ch;
            if (word_end)
                len_mem[count_reg[WordIdxW-1:0]] <= fill_reg + 1'b1;
        end
        rd_char_reg <= dict_mem[{cmd.scan_word, cmd.scan_pos}];
        rd_len_reg  <= len_mem[cmd.scan_word];
        pos_d_reg   <= cmd.scan_pos;
    end

    // window and history
    assign widx = rd_len_reg - 1'b1 - LenW'(pos_d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= (MaxWord+1)'(1);
            mis_reg  <= 1'b0;
            for (int i = 0; i < MaxWord; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (cmd.start_text)
            begin
                hist_reg <= (MaxWord+1)'(1);
                for (int i = 0; i < MaxWord; i++)
                    win_reg[i] <= '0;
            end
            else if (cmd.text_shift)
            begin
                hist_reg <= {hist_reg[MaxWord-1:0], 1'b0};
                win_reg[0] <= ch;
                for (int i = 1; i < MaxWord; i++)
                    win_reg[i] <= win_reg[i-1];
            end
            else if (cmd.set_hit)
                hist_reg[0] <= 1'b1;
            // per-word mismatch accumulator
            if (cmd.scan_start)
                mis_reg <= 1'b0;
            else if (cmd.cmp_step && rd_char_reg != win_reg[widx[PosW-1:0]])
                mis_reg <= 1'b1;
        end
    end

    assign stat.word_count = count_reg;
    assign stat.cur_len    = rd_len_reg;
    assign stat.len_ok     = rd_len_reg != '0 && hist_reg[rd_len_reg];
    assign stat.mismatch   = mis_reg;
    assign dropped         = drop_reg;
endmodule

### rtl/wbc_ctrl.sv
module wbc_ctrl
    import wbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       breakable,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat
);
    typedef enum logic [2:0] {
        S_IDLE, S_LEN, S_CMP, S_WAIT, S_NEXT, S_OUT
    } state_t;

    state_t              state_reg;
    logic [WordIdxW-1:0] word_reg;
    logic [PosW-1:0]     pos_reg;
    logic                brk_reg;
    logic                last_word, accept;

    assign in_ready  = state_reg == S_IDLE;
    assign accept    = in_valid && in_ready;
    assign out_valid = state_reg == S_OUT;
    assign breakable = brk_reg;
    assign last_word = CountW'(word_reg) + 1'b1 >= stat.word_count;

    // commands
    always_comb
    begin
        cmd = '0;
        cmd.scan_word = word_reg;
        cmd.scan_pos  = pos_reg;
        if (accept)
        begin
            cmd.clear_dict = op == OP_CLEAR;
            cmd.dict_char  = op == OP_DICT;
            cmd.start_text = op == OP_START;
            cmd.text_shift = op == OP_TEXT;
        end
        cmd.scan_start = state_reg == S_LEN;
        cmd.cmp_step   = state_reg == S_CMP || state_reg == S_WAIT;
        cmd.set_hit    = state_reg == S_NEXT && stat.len_ok && !stat.mismatch;
    end

    // sequencer: one word compared per pass, one character per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            word_reg  <= '0;
            pos_reg   <= '0;
            brk_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (accept)
                    begin
                        word_reg <= '0;
                        pos_reg  <= '0;
                        if (op == OP_START)
                        begin
                            brk_reg   <= stat.word_count != '0;
                            state_reg <= S_OUT;
                        end
                        else if (op == OP_TEXT)
                        begin
                            brk_reg   <= 1'b0;
                            state_reg <= (stat.word_count != '0) ? S_LEN : S_OUT;
                        end
                    end
                S_LEN:
                    state_reg <= S_CMP;
                S_CMP:
                    if (!stat.len_ok)
                        state_reg <= S_NEXT;
                    else if (LenW'(pos_reg) + 1'b1 >= stat.cur_len)
                        state_reg <= S_WAIT;
                    else
                        pos_reg <= pos_reg + 1'b1;
                S_WAIT:
                    state_reg <= S_NEXT;
                S_NEXT:
                begin
                    pos_reg <= '0;
                    if (stat.len_ok && !stat.mismatch)
                    begin
                        brk_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (last_word)
                        state_reg <= S_OUT;
                    else
                    begin
                        word_reg  <= word_reg + 1'b1;
                        state_reg <= S_LEN;
                    end
                end
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/word_break_checker_unit.sv
// channel | handshake          | payload
// in      | in_valid/in_ready   | op, ch, word_end
// out     | out_valid/out_ready | breakable, dict_dropped
// Dictionary items give no result; a start item gives its result next cycle.
// A text character scans stored words in order through the single dictionary
// read port, each word through S_LEN, S_CMP per character, S_WAIT and S_NEXT,
// or straight from S_CMP to S_NEXT where the prefix before the word is not
// breakable, stopping at the first fit, then presents its result in S_OUT.
// Reset (async, active low) empties the dictionary and starts a fresh text.
// A result waits in its register until taken; no new item is taken meanwhile.
module word_break_checker_unit
    import wbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] ch,
    input  logic       word_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       breakable,
    output logic       dict_dropped
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     dropped;

    wbc_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .op,
        .out_valid, .out_ready, .breakable, .cmd, .stat
    );

    wbc_datapath u_dp (
        .clk, .rst_n, .cmd, .ch, .word_end, .stat, .dropped
    );

    assign dict_dropped = dropped;
endmodule

### verif/word_break_checker_unit_tb.sv
`timescale 1ns / 1ps

module word_break_checker_unit_tb;
    import wbc_pkg::*;

    typedef struct {
        op_t        op;
        logic [7:0] ch;
        logic       word_end;
    } txn_t;

    typedef struct {
        logic breakable;
        logic dict_dropped;
    } verdict_t;

    localparam int CYCLE_LIMIT = 20000000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] op;
    logic [7:0] ch;
    logic       word_end;
    logic       out_valid;
    logic       out_ready;
    logic       breakable;
    logic       dict_dropped;

    word_break_checker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .ch           (ch),
        .word_end     (word_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .breakable    (breakable),
        .dict_dropped (dict_dropped)
    );

    // predictor state
    logic [7:0] pm_chars [NumWords][MaxWord];
    int         pm_lens [NumWords];
    int         pm_count;
    int         pm_fill;
    bit         pm_bad;
    logic [7:0] pm_window [MaxWord];
    bit         pm_hist [MaxWord+1];
    bit         pm_dropped;

    txn_t     pending_txns[$];
    verdict_t expected_verdicts[$];
    int       errors = 0;
    int       cycles = 0;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void pm_start_text();
        for (int i = 0; i < MaxWord; i++)
            pm_window[i] = 8'd0;
        for (int i = 0; i <= MaxWord; i++)
            pm_hist[i] = 1'b0;
        pm_hist[0] = 1'b1;
    endfunction

    function automatic void pm_clear_dict();
        pm_count   = 0;
        pm_fill    = 0;
        pm_bad     = 1'b0;
        pm_dropped = 1'b0;
    endfunction

    // Apply one accepted transaction, queueing the verdict it produces
    function automatic void predict_verdict(txn_t t);
        verdict_t v;
        bit       hit;
        bit       fits;
        int       len;
        hit = 1'b0;
        case (t.op)
            OP_CLEAR:
                pm_clear_dict();
            OP_DICT:
            begin
                if (pm_count >= NumWords || pm_fill >= MaxWord)
                    pm_bad = 1'b1;
                else if (!pm_bad)
                begin
                    pm_chars[pm_count][pm_fill] = t.ch;
                    pm_fill++;
                end
                if (t.word_end)
                begin
                    if (pm_bad)
                        pm_dropped = 1'b1;
                    else if (pm_fill > 0)
                    begin
                        pm_lens[pm_count] = pm_fill;
                        pm_count++;
                    end
                    pm_fill = 0;
                    pm_bad  = 1'b0;
                end
            end
            OP_START:
            begin
                pm_start_text();
                hit = pm_count > 0 && pm_hist[0];
            end
            default:
            begin
                for (int i = MaxWord; i > 0; i--)
                    pm_hist[i] = pm_hist[i-1];
                for (int i = MaxWord - 1; i > 0; i--)
                    pm_window[i] = pm_window[i-1];
                pm_window[0] = t.ch;
                for (int k = 0; k < pm_count && !hit; k++)
                begin
                    len  = pm_lens[k];
                    fits = pm_hist[len];
                    for (int i = 0; i < len && fits; i++)
                        if (pm_chars[k][i] != pm_window[len-1-i])
                            fits = 1'b0;
                    hit = fits;
                end
                pm_hist[0] = hit;
                hit = hit && pm_count > 0;
            end
        endcase
        if (t.op == OP_START || t.op == OP_TEXT)
        begin
            v.breakable    = hit;
            v.dict_dropped = pm_dropped;
            expected_verdicts.push_back(v);
        end
    endfunction

    function automatic void add_txn(op_t o, logic [7:0] c, logic e);
        txn_t t;
        t.op       = o;
        t.ch       = c;
        t.word_end = e;
        pending_txns.push_back(t);
    endfunction

    // small alphabet so that words actually match the text
    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 19) == 0)
            return 8'($urandom);
        return 8'("a" + $urandom_range(0, 2));
    endfunction

    function automatic void add_word(int len);
        for (int i = 0; i < len; i++)
            add_txn(OP_DICT, pick_char(), i == len - 1);
    endfunction

    // Driver: hold each transaction until accepted, random gap before the next
    int drv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op       <= OP_CLEAR;
            ch       <= 8'd0;
            word_end <= 1'b0;
            drv_gap  <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                predict_verdict('{op_t'(op), ch, word_end});
            if (drv_gap > 0 || pending_txns.size() == 0)
            begin
                in_valid <= 1'b0;
                if (drv_gap > 0)
                    drv_gap <= drv_gap - 1;
            end
            else
            begin
                txn_t t;
                t = pending_txns.pop_front();
                in_valid <= 1'b1;
                op       <= t.op;
                ch       <= t.ch;
                word_end <= t.word_end;
                drv_gap  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            end
        end
    end

    // Monitor: random back-pressure, compare each verdict with the oldest expected
    int mon_stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            mon_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                verdict_t v;
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected transaction breakable=%b dict_dropped=%b",
                             $time, breakable, dict_dropped);
                    errors++;
                end
                else
                begin
                    v = expected_verdicts.pop_front();
                    if (breakable !== v.breakable)
                    begin
                        $display("%0t: breakable expected %b actual %b",
                                 $time, v.breakable, breakable);
                        errors++;
                    end
                    if (dict_dropped !== v.dict_dropped)
                    begin
                        $display("%0t: dict_dropped expected %b actual %b",
                                 $time, v.dict_dropped, dict_dropped);
                        errors++;
                    end
                end
                mon_stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                out_ready <= 1'b0;
            end
            else if (mon_stall > 0)
            begin
                mon_stall <= mon_stall - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** word_break_checker_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int n;
        rst_n     = 1'b0;
        pm_clear_dict();
        pm_start_text();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: start and text with empty dictionary
        add_txn(OP_START, 8'hFF, 1'b1);
        add_txn(OP_TEXT, 8'h00, 1'b1);
        add_txn(OP_TEXT, 8'hFF, 1'b0);
        // words "a", byte 0xFF, byte 0x00
        add_txn(OP_DICT, "a", 1'b1);
        add_txn(OP_DICT, 8'hFF, 1'b1);
        add_txn(OP_DICT, 8'h00, 1'b1);
        // unfinished word across a text start
        add_txn(OP_DICT, "b", 1'b0);
        add_txn(OP_START, 8'h00, 1'b0);
        add_txn(OP_DICT, "c", 1'b1);
        add_txn(OP_TEXT, "a", 1'b0);
        add_txn(OP_TEXT, 8'hFF, 1'b1);
        add_txn(OP_TEXT, "b", 1'b0);
        add_txn(OP_TEXT, "c", 1'b0);
        add_txn(OP_TEXT, 8'h00, 1'b0);
        // overlong word of MaxWord+1 bytes, then a word of exactly MaxWord
        for (int i = 0; i <= MaxWord; i++)
            add_txn(OP_DICT, "a", i == MaxWord);
        add_txn(OP_TEXT, "a", 1'b0);
        for (int i = 0; i < MaxWord; i++)
            add_txn(OP_DICT, "b", i == MaxWord - 1);
        add_txn(OP_START, 8'h55, 1'b0);
        for (int i = 0; i < MaxWord; i++)
            add_txn(OP_TEXT, "b", 1'b0);
        // clear mid-word, keeps text history
        add_txn(OP_DICT, "a", 1'b0);
        add_txn(OP_CLEAR, 8'hAA, 1'b1);
        add_txn(OP_TEXT, "b", 1'b0);
        // full table then one more word
        for (int w = 0; w < NumWords; w++)
            add_word(1 + (w % 3));
        add_word(2);
        add_txn(OP_START, 8'h00, 1'b0);
        for (int i = 0; i < 10; i++)
            add_txn(OP_TEXT, pick_char(), 1'b0);
        add_txn(OP_CLEAR, 8'h00, 1'b0);

        // Random: mostly small dictionaries and well-formed texts
        n = 0;
        while (n < 750)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                add_txn(OP_CLEAR, 8'($urandom), 1'($urandom));
                n++;
            end
            else if (r < 20)
            begin
                int len;
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, MaxWord + 2)
                                                   : $urandom_range(1, 4);
                add_word(len);
                n += len;
            end
            else if (r < 25)
            begin
                add_txn(OP_DICT, 8'($urandom), 1'($urandom));
                n++;
            end
            else if (r < 32)
            begin
                add_txn(OP_START, 8'($urandom), 1'($urandom));
                n++;
            end
            else
            begin
                add_txn(OP_TEXT, pick_char(), 1'($urandom));
                n++;
            end
        end
        // bits of ch all toggled
        add_txn(OP_TEXT, 8'hFF, 1'b1);
        add_txn(OP_TEXT, 8'h00, 1'b0);

        wait (pending_txns.size() == 0 && !in_valid);
        wait (expected_verdicts.size() == 0);
        repeat (NumWords * (MaxWord + 3) + 50) @(posedge clk);
        if (errors == 0 && expected_verdicts.size() == 0)
            $display("** word_break_checker_unit: PASSED **");
        else
            $display("** word_break_checker_unit: FAILED **");
        $finish;
    end
endmodule
